// ===== hw/rtl/wlli_pkg.sv =====
// Package for the wavetable lookup unit: sizes, wave codes and the table builder.
package wlli_pkg;

  // Table and phase geometry.
  localparam int TABLE_SIZE = 64;
  localparam int PHASE_BITS = 24;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int FRAC_W     = PHASE_BITS;

  // Table entries are Q1.15 with +1.0 held as 32768, so they need 17 bits signed; 18 are used.
  localparam int ENTRY_W    = 18;
  localparam int SAMPLE_W   = 16;
  localparam int WAVE_W     = 3;

  // Configuration port geometry.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic signed [ENTRY_W-1:0] ENTRY_POS_ONE = 18'sd32768;
  localparam logic signed [ENTRY_W-1:0] ENTRY_NEG_ONE = -18'sd32768;

  // Register index of the wave selector.
  localparam logic REG_WAVE_TYPE = 1'b0;

  // Wave type codes. Codes 6 and 7 fall back to the sine table.
  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE    = 3'd0,
    WAVE_SAW     = 3'd1,
    WAVE_TRI     = 3'd2,
    WAVE_PULSE25 = 3'd3,
    WAVE_SQUARE  = 3'd4,
    WAVE_PULSE75 = 3'd5
  } wave_t;

  // Sine entry i of TABLE_SIZE in Q15. The angle is folded into the first
  // quadrant, then a Taylor series is evaluated in Q30 by Horner's rule.
  // Only used at elaboration to build the constant ROM.
  function automatic logic signed [ENTRY_W-1:0] sine_entry(input int idx);
    logic [63:0] n;
    logic [63:0] p;
    logic        neg;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] h;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    logic signed [ENTRY_W-1:0] res;
    n   = 64'(TABLE_SIZE);
    p   = 64'(2 * idx);
    neg = 1'b0;
    if (p >= n) begin
      p   = p - n;
      neg = 1'b1;
    end
    if (2 * p > n) begin
      p = n - p;
    end
    x  = (64'd3373259426 * p + n / 2) / 64'(TABLE_SIZE);
    x2 = (x * x) >> 30;
    h  = 64'd1 << 30;
    t  = ((x2 * h) >> 30) / 156;
    h  = (t >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - t;
    t  = ((x2 * h) >> 30) / 110;
    h  = (t >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - t;
    t  = ((x2 * h) >> 30) / 72;
    h  = (t >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - t;
    t  = ((x2 * h) >> 30) / 42;
    h  = (t >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - t;
    t  = ((x2 * h) >> 30) / 20;
    h  = (t >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - t;
    t  = ((x2 * h) >> 30) / 6;
    h  = (t >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - t;
    s  = (x * h) >> 30;
    q  = (s + (64'd1 << 14)) >> 15;
    if (q > 64'd32768) begin
      q = 64'd32768;
    end
    res = ENTRY_W'(q);
    if (neg) begin
      res = -res;
    end
    return res;
  endfunction

  // Entry i of the table for a given wave code. Triangle is handled apart
  // in the datapath since its table holds only two entries.
  function automatic logic signed [ENTRY_W-1:0] table_entry(input int wave, input int idx);
    logic signed [ENTRY_W-1:0] res;
    case (wave)
      WAVE_SAW: res = ENTRY_W'(32768 - (65536 * idx + TABLE_SIZE / 2) / TABLE_SIZE);
      WAVE_TRI: res = (idx == 0) ? ENTRY_POS_ONE : ENTRY_NEG_ONE;
      WAVE_PULSE25, WAVE_SQUARE, WAVE_PULSE75: begin
        res = (4 * idx < (wave - int'(WAVE_TRI)) * TABLE_SIZE) ? ENTRY_POS_ONE : ENTRY_NEG_ONE;
      end
      default: res = sine_entry(idx);
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/wavetable_lookup_linear_interp_unit.sv =====
// Wavetable oscillator lookup with linear interpolation between adjacent entries.
//
//   Channel   Signals                                   Direction  Handshake
//   input     start, busy, phase[23:0]                  in/out     start & !busy
//   result    done, sample[15:0] (signed Q1.15)         out        done strobe, one cycle
//   config    psel, penable, pwrite, paddr, pwdata,     in/out     APB write, pready high
//             prdata, pready
//
// One phase word is taken in every cycle; its sample passes the phase register
// and then the result register, which bracket the table read and interpolation
// multiply, and comes out with done high for one cycle. busy is always low.
// Synchronous reset clears wave_type to sine and drops all in-flight
// transactions. The receiver cannot stall the result stream.
module wavetable_lookup_linear_interp_unit
  import wlli_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // Input transaction
  input  logic                       start,
  output logic                       busy,
  input  logic [PHASE_BITS-1:0]      phase,
  // Result transaction
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] sample,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_ADDR_W-1:0]      paddr,
  input  logic [APB_DATA_W-1:0]      pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int PROD_W    = ENTRY_W + FRAC_W + 1;
  localparam int SUM_W     = ENTRY_W + 1;

  // Pulse thresholds, compared against four times the entry index.
  localparam int POS_W = IDX_W + 2;
  localparam logic [POS_W-1:0] PULSE25_LIMIT = POS_W'(TABLE_SIZE);
  localparam logic [POS_W-1:0] SQUARE_LIMIT  = POS_W'(2 * TABLE_SIZE);
  localparam logic [POS_W-1:0] PULSE75_LIMIT = POS_W'(3 * TABLE_SIZE);

  logic [WAVE_W-1:0]       wave_type;
  logic                    in_valid;
  logic [PHASE_BITS-1:0]   phase_q;

  logic signed [ENTRY_W-1:0] sine_rom [TABLE_SIZE];
  logic signed [ENTRY_W-1:0] saw_rom  [TABLE_SIZE];

  logic                       is_tri;
  logic [IDX_W-1:0]           left_idx;
  logic [IDX_W-1:0]           right_idx;
  logic signed [ENTRY_W-1:0]  left_val;
  logic signed [ENTRY_W-1:0]  right_val;
  logic [FRAC_W-1:0]          frac;
  logic signed [ENTRY_W-1:0]  diff;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   prod_rnd;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] sample_next;

  // Constant sine and sawtooth tables, built at elaboration.
  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_entry
    assign sine_rom[i] = table_entry(int'(WAVE_SINE), i);
    assign saw_rom[i]  = table_entry(int'(WAVE_SAW), i);
  end

  // Table entry for one index. Pulse levels come from a threshold compare,
  // and the unused codes read the sine table.
  function automatic logic signed [ENTRY_W-1:0] entry_lookup(
    input logic [WAVE_W-1:0] wave, input logic [IDX_W-1:0] idx);
    logic [POS_W-1:0]          pos;
    logic signed [ENTRY_W-1:0] res;
    pos = {idx, 2'b00};
    unique case (wave)
      WAVE_SAW:     res = saw_rom[idx];
      WAVE_PULSE25: res = (pos < PULSE25_LIMIT) ? ENTRY_POS_ONE : ENTRY_NEG_ONE;
      WAVE_SQUARE:  res = (pos < SQUARE_LIMIT) ? ENTRY_POS_ONE : ENTRY_NEG_ONE;
      WAVE_PULSE75: res = (pos < PULSE75_LIMIT) ? ENTRY_POS_ONE : ENTRY_NEG_ONE;
      default:      res = sine_rom[idx];
    endcase
    return res;
  endfunction

  // Configuration port: single register, no wait states.
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_type <= WAVE_SINE;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_WAVE_TYPE) begin
      wave_type <= pwdata[WAVE_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_WAVE_TYPE) begin
      prdata = {{(APB_DATA_W-WAVE_W){1'b0}}, wave_type};
    end else begin
      prdata = '0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      phase_q <= phase;
    end
  end

  // Index and fraction: top phase bits pick the entry, the rest interpolate.
  assign is_tri    = (wave_type == WAVE_TRI);
  assign left_idx  = phase_q[PHASE_BITS-1 -: IDX_W];
  assign right_idx = left_idx + IDX_W'(1);

  always_comb begin
    if (is_tri) begin
      left_val  = phase_q[PHASE_BITS-1] ? ENTRY_NEG_ONE : ENTRY_POS_ONE;
      right_val = phase_q[PHASE_BITS-1] ? ENTRY_POS_ONE : ENTRY_NEG_ONE;
      frac      = {phase_q[PHASE_BITS-2:0], 1'b0};
    end else begin
      left_val  = entry_lookup(wave_type, left_idx);
      right_val = entry_lookup(wave_type, right_idx);
      frac      = {phase_q[PHASE_BITS-IDX_W-1:0], {IDX_W{1'b0}}};
    end
  end

  // Interpolate as L + round((R - L) * f / 2^PB), then clip +1.0 to full scale.
  assign diff     = right_val - left_val;
  assign prod     = PROD_W'(diff) * $signed({1'b0, frac});
  assign prod_rnd = prod + (PROD_W'(1) <<< (FRAC_W - 1));
  assign sum      = SUM_W'(left_val) + prod_rnd[PROD_W-1 -: SUM_W];

  always_comb begin
    if (sum > SUM_W'(32767)) begin
      sample_next = 16'sh7FFF;
    end else if (sum < -SUM_W'(32768)) begin
      sample_next = -16'sh8000;
    end else begin
      sample_next = sum[SAMPLE_W-1:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      sample <= sample_next;
    end
  end

endmodule

// ===== tb/sv/wavetable_lookup_linear_interp_unit_test.sv =====
// Self-checking testbench for the wavetable lookup and linear interpolation unit.
`timescale 1ns / 100ps

module wavetable_lookup_linear_interp_unit_test
  import wlli_pkg::*;
();

  // Spare wave codes that select the sine table, and a register index outside the map.
  localparam logic [WAVE_W-1:0] WAVE_SPARE6 = 3'd6;
  localparam logic [WAVE_W-1:0] WAVE_SPARE7 = 3'd7;
  localparam int REG_UNMAPPED = 1;

  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SEGMENTS      = 12;
  localparam int SEGMENT_ITEMS = 154;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic [PHASE_BITS-1:0]      phase;
  logic                       done;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [APB_ADDR_W-1:0]      paddr;
  logic [APB_DATA_W-1:0]      pwdata;
  logic [APB_DATA_W-1:0]      prdata;
  logic                       pready;

  // Expected sample together with the transaction that caused it.
  typedef struct {
    logic [WAVE_W-1:0]          wave;
    logic [PHASE_BITS-1:0]      ph;
    logic signed [SAMPLE_W-1:0] value;
  } sample_entry_t;

  // One row of the directed vectors: an optional register write, then one phase word.
  typedef struct packed {
    bit                         wr;
    int                         reg_idx;
    logic [31:0]                wdata;
    logic [PHASE_BITS-1:0]      ph;
    bit                         known;
    logic signed [SAMPLE_W-1:0] kval;
  } vector_t;

  sample_entry_t              pending_samples[$];
  logic [WAVE_W-1:0]          wave_cfg;
  int                         sine_rom[TABLE_SIZE];
  bit                         row_known;
  logic signed [SAMPLE_W-1:0] row_value;
  int                         mismatches;
  int                         cycle_count;
  int                         no_idle_left;

  // Directed vectors: known samples are typed in only where they are obvious.
  vector_t directed [22] = '{
    '{1'b0, 0, 32'd0, 24'h000000, 1'b1, 16'sd0},
    '{1'b0, 0, 32'd0, 24'h400000, 1'b0, 16'sd0},
    '{1'b0, 0, 32'd0, 24'hFFFFFF, 1'b0, 16'sd0},
    '{1'b0, 0, 32'd0, 24'h555555, 1'b0, 16'sd0},
    '{1'b1, int'(REG_WAVE_TYPE), 32'(WAVE_SAW), 24'h000000, 1'b1, 16'sd32767},
    '{1'b0, 0, 32'd0, 24'hFFFFFF, 1'b0, 16'sd0},
    '{1'b0, 0, 32'd0, 24'h800000, 1'b1, 16'sd0},
    '{1'b1, int'(REG_WAVE_TYPE), 32'(WAVE_TRI), 24'h000000, 1'b1, 16'sd32767},
    '{1'b0, 0, 32'd0, 24'h400000, 1'b1, 16'sd0},
    '{1'b0, 0, 32'd0, 24'h800000, 1'b1, -16'sd32768},
    '{1'b0, 0, 32'd0, 24'hFFFFFF, 1'b0, 16'sd0},
    '{1'b1, int'(REG_WAVE_TYPE), 32'(WAVE_PULSE25), 24'h000000, 1'b1, 16'sd32767},
    '{1'b0, 0, 32'd0, 24'h400000, 1'b1, -16'sd32768},
    '{1'b0, 0, 32'd0, 24'h3FFFFF, 1'b0, 16'sd0},
    '{1'b1, int'(REG_WAVE_TYPE), 32'(WAVE_SQUARE), 24'h800000, 1'b1, -16'sd32768},
    '{1'b0, 0, 32'd0, 24'h7FFFFF, 1'b0, 16'sd0},
    '{1'b1, int'(REG_WAVE_TYPE), 32'(WAVE_PULSE75), 24'hC00000, 1'b1, -16'sd32768},
    '{1'b0, 0, 32'd0, 24'hBFFFFF, 1'b0, 16'sd0},
    '{1'b1, int'(REG_WAVE_TYPE), 32'(WAVE_SPARE6), 24'h000000, 1'b1, 16'sd0},
    '{1'b1, int'(REG_WAVE_TYPE), 32'(WAVE_SPARE7), 24'h123456, 1'b0, 16'sd0},
    '{1'b1, REG_UNMAPPED, 32'(WAVE_SQUARE), 24'h000000, 1'b1, 16'sd0},
    '{1'b1, int'(REG_WAVE_TYPE), 32'hFFFF_FFF9, 24'h000001, 1'b0, 16'sd0}
  };

  wavetable_lookup_linear_interp_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .phase   (phase),
    .done    (done),
    .sample  (sample),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Free-running clock, 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Build the sine table: fold into the first quadrant, then a Horner Taylor series in Q30.
  initial begin : build_sine
    int          taylor_div[6];
    logic [63:0] n;
    logic [63:0] a;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] h;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    bit          neg;
    taylor_div = '{156, 110, 72, 42, 20, 6};
    n = 64'(TABLE_SIZE);
    for (int k = 0; k < TABLE_SIZE; k++) begin
      a   = 64'(2 * k);
      neg = 1'b0;
      if (a >= n) begin
        a   = a - n;
        neg = 1'b1;
      end
      if (2 * a > n) begin
        a = n - a;
      end
      x  = (PI_Q30 * a + n / 2) / n;
      x2 = (x * x) >> 30;
      h  = ONE_Q30;
      for (int j = 0; j < 6; j++) begin
        t = ((x2 * h) >> 30) / 64'(taylor_div[j]);
        h = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
      end
      s = (x * h) >> 30;
      q = (s + (64'd1 << 14)) >> 15;
      if (q > 64'd32768) begin
        q = 64'd32768;
      end
      sine_rom[k] = neg ? -int'(q) : int'(q);
    end
  end

  // Table entry in Q1.15 with +1.0 held as 32768.
  function automatic int wave_entry(input logic [WAVE_W-1:0] wave, input int idx);
    case (wave)
      WAVE_SAW: begin
        return 32768 - (65536 * idx + TABLE_SIZE / 2) / TABLE_SIZE;
      end
      WAVE_TRI: begin
        return (idx == 0) ? 32768 : -32768;
      end
      // The high part covers one, two or three quarters of the table.
      WAVE_PULSE25, WAVE_SQUARE, WAVE_PULSE75: begin
        return (4 * idx < (int'(wave) - int'(WAVE_TRI)) * TABLE_SIZE) ? 32768 : -32768;
      end
      default: begin
        return sine_rom[idx];
      end
    endcase
  endfunction

  // Interpolated, rounded and saturated sample for one phase word.
  function automatic logic signed [SAMPLE_W-1:0] interpolate_sample(
    input logic [WAVE_W-1:0] wave, input logic [PHASE_BITS-1:0] ph);
    longint size;
    longint prod;
    longint frac;
    longint lo_i;
    longint hi_i;
    longint acc;
    longint rounded;
    size = (wave == WAVE_TRI) ? 2 : TABLE_SIZE;
    prod = longint'(ph) * size;
    lo_i = prod >>> PHASE_BITS;
    frac = prod & ((longint'(1) << PHASE_BITS) - 1);
    hi_i = (lo_i + 1 >= size) ? 0 : lo_i + 1;
    acc  = longint'(wave_entry(wave, int'(lo_i))) * ((longint'(1) << PHASE_BITS) - frac)
         + longint'(wave_entry(wave, int'(hi_i))) * frac;
    rounded = ((acc + (longint'(32768) << PHASE_BITS) + (longint'(1) << (PHASE_BITS - 1)))
              >>> PHASE_BITS) - 32768;
    if (rounded > 32767) begin
      rounded = 32767;
    end
    if (rounded < -32768) begin
      rounded = -32768;
    end
    return SAMPLE_W'(rounded);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Monitor: check results, predict accepted transactions and track register writes.
  always @(posedge clk) begin : monitor
    sample_entry_t got;
    sample_entry_t want;
    if (rst) begin
      wave_cfg = WAVE_SINE;
      pending_samples.delete();
    end else begin
      if (done) begin
        if (pending_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected sample %0d", sample));
        end else begin
          want = pending_samples.pop_front();
          if (sample !== want.value) begin
            report_mismatch($sformatf("wave %0d phase %06h: sample %0d, want %0d",
                                      want.wave, want.ph, sample, want.value));
          end
        end
      end
      if (start && !busy) begin
        got.wave  = wave_cfg;
        got.ph    = phase;
        got.value = row_known ? row_value : interpolate_sample(wave_cfg, phase);
        pending_samples.push_back(got);
      end
      if (psel && penable && pwrite && pready &&
          paddr == APB_ADDR_W'(4 * int'(REG_WAVE_TYPE))) begin
        wave_cfg = pwdata[WAVE_W-1:0];
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Register write: setup cycle, then access cycle until pready.
  task automatic apb_write(input int reg_idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * reg_idx);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every expected sample has come out, then let the pipeline settle.
  task automatic wait_idle();
    while (pending_samples.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Offer one phase word after a random gap and hold it until accepted.
  task automatic drive_item(input logic [PHASE_BITS-1:0] ph, input bit known,
                            input logic signed [SAMPLE_W-1:0] kval);
    int gap;
    int roll;
    if (no_idle_left > 0) begin
      no_idle_left--;
      gap = 0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        gap = 0;
      end else if (roll < 90) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(5, 40);
      end
      if ($urandom_range(0, 49) == 0) begin
        no_idle_left = $urandom_range(20, 80);
      end
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     <= 1'b1;
    phase     <= ph;
    row_known <= known;
    row_value <= kval;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Stimulus: reset, directed vectors, then random segments over all wave codes.
  initial begin
    logic [WAVE_W-1:0]     seg_wave;
    logic [PHASE_BITS-1:0] ph;
    logic [17:0]           seg_frac;
    int                    sel;
    rst          = 1'b1;
    start        = 1'b0;
    phase        = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    row_known    = 1'b0;
    row_value    = '0;
    mismatches   = 0;
    cycle_count  = 0;
    no_idle_left = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[r]) begin
      if (directed[r].wr) begin
        start <= 1'b0;
        wait_idle();
        apb_write(directed[r].reg_idx, directed[r].wdata);
      end
      drive_item(directed[r].ph, directed[r].known, directed[r].kval);
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      seg_wave = (seg < 8) ? WAVE_W'(seg) : WAVE_W'($urandom_range(0, 7));
      start <= 1'b0;
      wait_idle();
      if ($urandom_range(0, 2) == 0) begin
        apb_write(REG_UNMAPPED, $urandom);
      end
      apb_write(int'(REG_WAVE_TYPE), ($urandom & ~32'h7) | 32'(seg_wave));
      for (int k = 0; k < SEGMENT_ITEMS; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          ph = PHASE_BITS'($urandom);
        end else if (sel < 85) begin
          // Land on, next to or halfway between table segment boundaries.
          case ($urandom_range(0, 3))
            0: seg_frac = 18'h00000;
            1: seg_frac = 18'h00001;
            2: seg_frac = 18'h3FFFF;
            default: seg_frac = 18'h20000;
          endcase
          ph = {6'($urandom_range(0, 63)), seg_frac};
        end else begin
          case ($urandom_range(0, 3))
            0: ph = 24'h000000;
            1: ph = 24'hFFFFFF;
            2: ph = 24'h800000;
            default: ph = 24'h7FFFFF;
          endcase
        end
        drive_item(ph, 1'b0, '0);
      end
    end

    start <= 1'b0;
    wait_idle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
